### design/mkp_pkg.sv
// Package for the matrix keypad long-press block: register indexes, reset
// values, shared structs and the one-low-line nibble decoder.
// No dependencies.
package mkp_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned CodeW  = 5;
  localparam int unsigned KeyW   = 6;
  localparam int unsigned IdxW   = 2;

  localparam logic [IdxW-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [IdxW-1:0] CFG_SHORT    = 2'd1;
  localparam logic [IdxW-1:0] CFG_REPEAT   = 2'd2;

  localparam logic [CountW-1:0] DEBOUNCE_RST = 8'd3;
  localparam logic [CountW-1:0] SHORT_RST    = 8'd25;
  localparam logic [CountW-1:0] REPEAT_RST   = 8'd10;

  localparam logic [3:0]        NIB_IDLE  = 4'hF;
  localparam logic [CountW-1:0] COUNT_MAX = 8'hFF;
  localparam logic [KeyW-1:0]   LONG_OFS  = 6'd20;
  localparam logic [CodeW-1:0]  CODE_BASE = 5'd4;

  typedef struct packed {
    logic [CountW-1:0] debounce_ticks;
    logic [CountW-1:0] short_limit;
    logic [CountW-1:0] repeat_ticks;
  } mkp_cfg_t;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key_code;
    logic            long_press;
  } mkp_res_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] pos;
  } mkp_line_t;

  // Position of the single low line counted from bit 3; ok is clear when
  // the nibble does not have exactly one low line.
  function automatic mkp_line_t single_low(input logic [3:0] nib);
    mkp_line_t r;
    r.ok  = 1'b1;
    r.pos = 2'd0;
    unique case (nib)
      4'h7:    r.pos = 2'd0;
      4'hB:    r.pos = 2'd1;
      4'hD:    r.pos = 2'd2;
      4'hE:    r.pos = 2'd3;
      default: r.ok  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### design/mkp_if.sv
// Channel interfaces of the matrix keypad block: scan ticks in, key codes
// out and register writes. No dependencies.
interface mkp_scan_if;
  logic       valid;
  logic       ready;
  logic [3:0] row_lines;
  logic [3:0] col_lines;
  modport source (output valid, row_lines, col_lines, input ready);
  modport sink   (input valid, row_lines, col_lines, output ready);
endinterface

interface mkp_key_if;
  logic       valid;
  logic       ready;
  logic [5:0] key_code;
  logic       long_press;
  modport source (output valid, key_code, long_press, input ready);
  modport sink   (input valid, key_code, long_press, output ready);
endinterface

interface mkp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/matrix_keypad_long_press.sv
// Matrix keypad scanner with debounce, short press, long press and
// auto-repeat for a 4x4 active-low keypad. Each beat on the scan channel is
// one scan tick carrying the row and column nibbles. A key must be seen for
// debounce_ticks ticks before it is taken; releasing it within short_limit
// held ticks gives the short code (4..19), holding it longer gives the long
// code (short plus 20, long_press set) every repeat_ticks ticks. Patterns
// with more or fewer than one low line are ignored at acceptance. Ticks go
// through an input register and combinational state logic into a result
// register, so a tick is taken every cycle and its key code, if any, leaves
// from the result register; only a stalled key channel holds the scan
// channel back. Registers may be written only while the block is idle.
// Depends on mkp_pkg, the interfaces in mkp_if and mkp_fsm.
module matrix_keypad_long_press
  import mkp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mkp_scan_if.sink   scan_i,
  mkp_cfg_if.sink    cfg_i,
  mkp_key_if.source  key_o
);

  // Configuration registers, written one beat at a time.
  mkp_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= DEBOUNCE_RST;
      cfg_q.short_limit    <= SHORT_RST;
      cfg_q.repeat_ticks   <= REPEAT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_i.data;
        CFG_SHORT:    cfg_q.short_limit    <= cfg_i.data;
        CFG_REPEAT:   cfg_q.repeat_ticks   <= cfg_i.data;
        default:      ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // Input stage. It moves on whenever the result register is free or is
  // being emptied this cycle, which keeps one tick per cycle flowing.
  logic       in_vld_q;
  logic [3:0] row_q, col_q;
  logic       advance;

  assign advance      = in_vld_q && (!key_o.valid || key_o.ready);
  assign scan_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (scan_i.ready) begin
      in_vld_q <= scan_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_i.valid && scan_i.ready) begin
      row_q <= scan_i.row_lines;
      col_q <= scan_i.col_lines;
    end
  end

  // Keypad state logic: the held tick is applied to the state as it leaves
  // the input stage.
  mkp_res_t res;

  mkp_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .row_i  (row_q),
    .col_i  (col_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Result register.
  logic            out_vld_q;
  logic [KeyW-1:0] code_q;
  logic            long_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res.valid;
    end else if (key_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      code_q <= res.key_code;
      long_q <= res.long_press;
    end
  end

  assign key_o.valid      = out_vld_q;
  assign key_o.key_code   = code_q;
  assign key_o.long_press = long_q;

endmodule

### design/mkp_fsm.sv
// Keypad state: debounce counter, held phase, repeat counter and held code.
// One scan tick is applied per enabled cycle. Depends on mkp_pkg.
module mkp_fsm
  import mkp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [3:0] row_i,
  input  logic [3:0] col_i,
  input  mkp_cfg_t   cfg_i,
  output mkp_res_t   res_o
);

  logic              held_q, held_d;
  logic [CountW-1:0] press_q, press_d;
  logic [CountW-1:0] rep_q, rep_d;
  logic [CodeW-1:0]  code_q, code_d;

  mkp_line_t   row_dec, col_dec;
  logic [CountW-1:0] press_inc;
  logic [CodeW-1:0]  new_code;

  assign row_dec   = single_low(row_i);
  assign col_dec   = single_low(col_i);
  assign press_inc = press_q + 1'b1;
  assign new_code  = CODE_BASE + {1'b0, row_dec.pos, 2'b00} + {3'b000, col_dec.pos};

  always_comb begin
    held_d = held_q;
    press_d = press_q;
    rep_d = rep_q;
    code_d = code_q;
    res_o = '0;
    if (!held_q) begin
      press_d = (row_i != NIB_IDLE) ? press_inc : '0;
      if (press_d == cfg_i.debounce_ticks) begin
        press_d = '0;
        if (row_dec.ok && col_dec.ok) begin
          code_d = new_code;
          held_d = 1'b1;
          rep_d  = '0;
        end
      end
    end else if (col_i == NIB_IDLE) begin
      // Release: a short code only if the hold never passed the short limit.
      held_d  = 1'b0;
      press_d = '0;
      rep_d   = '0;
      res_o.valid      = (press_q <= cfg_i.short_limit);
      res_o.key_code   = {1'b0, code_q};
      res_o.long_press = 1'b0;
    end else begin
      if (press_q <= cfg_i.short_limit) begin
        if (press_q != COUNT_MAX) begin
          press_d = press_inc;
        end
      end else begin
        rep_d = rep_q + 1'b1;
      end
      if ((press_d > cfg_i.short_limit) && (rep_d >= cfg_i.repeat_ticks)) begin
        rep_d = '0;
        res_o.valid      = 1'b1;
        res_o.key_code   = {1'b0, code_q} + LONG_OFS;
        res_o.long_press = 1'b1;
      end
    end
    if (!step_i) begin
      res_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      press_q <= '0;
      rep_q   <= '0;
      code_q  <= '0;
    end else if (step_i) begin
      held_q  <= held_d;
      press_q <= press_d;
      rep_q   <= rep_d;
      code_q  <= code_d;
    end
  end

endmodule
